// ===== rtl/sfc_pkg.sv =====
package sfc_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int REG_COUNT      = 8;
    localparam int REG_IDX_BITS   = 3;
    localparam int REG_BITS       = 64;
    localparam int Q_BITS         = 32;
    localparam int N_BITS         = 16;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = 2;

    typedef enum logic [2:0] {
        REG_X_LO   = 3'd0,
        REG_X_HI   = 3'd1,
        REG_Y_LO   = 3'd2,
        REG_Y_HI   = 3'd3,
        REG_Z_LO   = 3'd4,
        REG_Z_HI   = 3'd5,
        REG_CLIP   = 3'd6,
        REG_NORMAL = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        CULL_NONE   = 3'd0,
        CULL_NEAR   = 3'd1,
        CULL_FAR    = 3'd2,
        CULL_LEFT   = 3'd3,
        CULL_RIGHT  = 3'd4,
        CULL_TOP    = 3'd5,
        CULL_BOTTOM = 3'd6
    } t_cull;

endpackage

// ===== rtl/sphere_frustum_cull_top.sv =====
// Sphere-vs-frustum culling engine.
// Input stream (s_axis): one bounding sphere per request; tdata packs
// center_x, center_y, center_z (signed Q16.16) and sphere_radius (31 bits).
// Output stream (m_axis): one result per sphere, in order; tdata packs
// visible and cull_reason.
// Config: i_cfg_we/i_cfg_idx/i_cfg_data write the 3x4 view matrix, the clip
// depths and the plane normals; write only while the engine is empty.
// Throughput: one sphere per cycle while m_axis is ready. Path: 3 transform
// stages, a queue pass, 2 test stages and the output register.
// The front (transform) advances every cycle; s_axis_tready is high only
// while the queue is empty or holds one entry that is read this cycle, so
// the 4-entry queue always has room for the 3 front stages plus its own
// entry. The back (tests) advances when its output may move; a stall on
// m_axis freezes the back and keeps s_axis_tready high only while the queue
// is empty; meanwhile the front drains into the queue.
// Reset clears all config registers to zero (every sphere visible) and empties
// every stage; no clearing pass is needed.
module sphere_frustum_cull_top import sfc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // center_x[31:0], center_y[63:32], center_z[95:64], sphere_radius[126:96]
    input  logic [127:0]              s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // visible[0], cull_reason[3:1]
    output logic [7:0]                m_axis_tdata,
    input  logic                      i_cfg_we,
    input  logic [REG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [REG_BITS-1:0]       i_cfg_data
);
    localparam int QW = 3 * COORD_BITS + 31;

    logic [REG_BITS-1:0] r_regs [REG_COUNT];
    logic f_valid;
    logic signed [COORD_BITS-1:0] f_x, f_y, f_z;
    logic [30:0] f_rad;
    logic [QW-1:0] q_out;
    logic q_empty, q_rd, b_en, b_valid;
    logic [FIFO_PTR_BITS:0] q_cnt;
    t_cull b_reason;
    logic r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) r_regs[i] <= '0;
        end else if (i_cfg_we) begin
            r_regs[i_cfg_idx] <= i_cfg_data;
        end
    end

    // accept only when queue + 3 front stages cannot exceed the queue depth
    assign s_axis_tready = (q_cnt == '0) || ((q_cnt == 3'd1) && q_rd);

    sfc_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(1'b1),
        .i_valid(s_axis_tvalid && s_axis_tready),
        .i_cx(s_axis_tdata[31:0]), .i_cy(s_axis_tdata[63:32]),
        .i_cz(s_axis_tdata[95:64]), .i_rad(s_axis_tdata[126:96]),
        .i_regs(r_regs), .o_valid(f_valid),
        .o_x(f_x), .o_y(f_y), .o_z(f_z), .o_rad(f_rad)
    );

    sfc_fifo #(.W(QW)) u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr(f_valid), .i_data({f_rad, f_z, f_y, f_x}),
        .i_rd(q_rd), .o_data(q_out), .o_empty(q_empty), .o_count(q_cnt)
    );

    assign b_en = !r_out_v || m_axis_tready;
    assign q_rd = b_en && !q_empty;

    sfc_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(b_en), .i_valid(q_rd),
        .i_x(q_out[COORD_BITS-1:0]), .i_y(q_out[2*COORD_BITS-1:COORD_BITS]),
        .i_z(q_out[3*COORD_BITS-1:2*COORD_BITS]), .i_rad(q_out[QW-1:3*COORD_BITS]),
        .i_clip(r_regs[REG_CLIP]), .i_norm(r_regs[REG_NORMAL]),
        .o_valid(b_valid), .o_reason(b_reason)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (b_en) begin
            r_out_v <= b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) m_axis_tdata <= {4'd0, b_reason, (b_reason == CULL_NONE)};
    end

    assign m_axis_tvalid = r_out_v;
endmodule

// ===== rtl/sfc_front.sv =====
// Front: world-to-view transform, three pipeline stages.
module sfc_front import sfc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [Q_BITS-1:0]     i_cx,
    input  logic signed [Q_BITS-1:0]     i_cy,
    input  logic signed [Q_BITS-1:0]     i_cz,
    input  logic        [30:0]           i_rad,
    input  logic        [REG_BITS-1:0]   i_regs [REG_COUNT],
    output logic                         o_valid,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y,
    output logic signed [COORD_BITS-1:0] o_z,
    output logic        [30:0]           o_rad
);
    localparam int PW = 2 * Q_BITS;
    localparam int SW = PW + 2;
    localparam int TW = SW - 16 + 1;

    logic [2:0] r_v;
    logic signed [PW-1:0] r_p [3][3];
    logic signed [Q_BITS-1:0] r_t1 [3];
    logic [30:0] r_rad1, r_rad2;
    logic signed [TW-1:0] r_s [3];

    function automatic logic signed [Q_BITS-1:0] ent(input logic [REG_BITS-1:0] v,
                                                     input logic hi);
        ent = hi ? v[63:32] : v[31:0];
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] lim_hi;
        logic signed [TW-1:0] lim_lo;
        lim_hi = (TW'(1) <<< (COORD_BITS - 1)) - TW'(1);
        lim_lo = -(TW'(1) <<< (COORD_BITS - 1));
        if (v > lim_hi) sat = lim_hi[COORD_BITS-1:0];
        else if (v < lim_lo) sat = lim_lo[COORD_BITS-1:0];
        else sat = v[COORD_BITS-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_p[c][0] <= i_cx * ent(i_regs[2*c], 1'b0);
                r_p[c][1] <= i_cy * ent(i_regs[2*c], 1'b1);
                r_p[c][2] <= i_cz * ent(i_regs[2*c+1], 1'b0);
                r_t1[c]   <= ent(i_regs[2*c+1], 1'b1);
                r_s[c] <= TW'((SW'(r_p[c][0]) + SW'(r_p[c][1]) + SW'(r_p[c][2])) >>> 16)
                          + TW'(r_t1[c]);
            end
            r_rad1 <= i_rad;
            r_rad2 <= r_rad1;
            o_x   <= sat(r_s[0]);
            o_y   <= sat(r_s[1]);
            o_z   <= sat(r_s[2]);
            o_rad <= r_rad2;
        end
    end

    assign o_valid = r_v[2];
endmodule

// ===== rtl/sfc_fifo.sv =====
// Small queue between front and back.
module sfc_fifo import sfc_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_data,
    input  logic         i_rd,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic [FIFO_PTR_BITS:0] o_count
);
    logic [W-1:0] r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wp, r_rp;
    logic [FIFO_PTR_BITS:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 1'b1;
            if (i_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (FIFO_PTR_BITS+1)'(i_wr) - (FIFO_PTR_BITS+1)'(i_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (FIFO_PTR_BITS+1)'(FIFO_DEPTH)) |-> !i_wr || i_rd)
        else $error("queue overflow");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_empty) else $error("queue underflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH)) else $error("count range");
`endif
endmodule

// ===== rtl/sfc_back.sv =====
// Back: plane tests on view-space centre, two stages.
module sfc_back import sfc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic signed [COORD_BITS-1:0] i_z,
    input  logic        [30:0]           i_rad,
    input  logic        [REG_BITS-1:0]   i_clip,
    input  logic        [REG_BITS-1:0]   i_norm,
    output logic                         o_valid,
    output t_cull                        o_reason
);
    // radius << 14 needs 46 bits signed; clip depths and radius need 32
    localparam int PW = COORD_BITS + N_BITS;
    localparam int DW = ((PW > 46) ? PW : 46) + 2;
    localparam int CW = ((COORD_BITS > Q_BITS) ? COORD_BITS : Q_BITS) + 2;

    logic [1:0] r_v;
    logic signed [PW-1:0] r_xn, r_zs, r_yn, r_zv;
    logic signed [DW-1:0] r_rs;
    logic r_near, r_far;
    t_cull n_reason;

    logic signed [N_BITS-1:0] snx, snz, vny, vnz;
    logic signed [CW-1:0] z_e, r_e, near_e, far_e;
    logic signed [DW-1:0] l_d, rt_d, t_d, b_d;

    assign snx = i_norm[15:0];
    assign snz = i_norm[31:16];
    assign vny = i_norm[47:32];
    assign vnz = i_norm[63:48];
    assign z_e = CW'(i_z);
    assign r_e = CW'($signed({1'b0, i_rad}));
    assign near_e = CW'($signed(i_clip[31:0]));
    assign far_e  = CW'($signed(i_clip[63:32]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_near <= (z_e + r_e) < near_e;
            r_far  <= (z_e - r_e) > far_e;
            r_xn <= i_x * snx;
            r_zs <= i_z * snz;
            r_yn <= i_y * vny;
            r_zv <= i_z * vnz;
            r_rs <= DW'($signed({1'b0, i_rad})) <<< 14;
            o_reason <= n_reason;
        end
    end

    // n.p > r  <=>  products sum > r<<14 exactly
    assign l_d  = DW'(r_zs) - DW'(r_xn);
    assign rt_d = DW'(r_zs) + DW'(r_xn);
    assign t_d  = DW'(r_zv) + DW'(r_yn);
    assign b_d  = DW'(r_zv) - DW'(r_yn);

    always_comb begin
        if (r_near) n_reason = CULL_NEAR;
        else if (r_far) n_reason = CULL_FAR;
        else if (l_d > r_rs) n_reason = CULL_LEFT;
        else if (rt_d > r_rs) n_reason = CULL_RIGHT;
        else if (t_d > r_rs) n_reason = CULL_TOP;
        else if (b_d > r_rs) n_reason = CULL_BOTTOM;
        else n_reason = CULL_NONE;
    end

    assign o_valid = r_v[1];
endmodule

// ===== tb/tb_sphere_frustum_cull_top.sv =====
`timescale 1ns / 1ps

module tb_sphere_frustum_cull_top;
    import sfc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ZERO_ROWS   = 6;
    localparam int DIR_ROWS    = 20;

    logic           i_clk;
    logic           i_rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [127:0]   s_axis_tdata;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [7:0]     m_axis_tdata;
    logic           i_cfg_we;
    logic [2:0]     i_cfg_idx;
    logic [63:0]    i_cfg_data;

    typedef struct packed {
        logic  visible;
        t_cull reason;
    } cull_t;

    // one per request in drive order: typed answer or predictor
    typedef struct packed {
        logic  typed;
        cull_t res;
    } answer_t;

    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [30:0] rad;
        logic        typed;
        cull_t       res;
    } row_t;

    logic [63:0] cull_regs [8];
    cull_t       pending_culls[$];
    answer_t     answer_q[$];
    int          n_errors;
    int          cycles;
    int          src_idle;
    int          dst_idle;
    row_t        dir_rows [DIR_ROWS];

    sphere_frustum_cull_top u_top (.*);

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor: world centre -> view space, then plane tests in order
    // ---------------------------------------------------------------
    function automatic logic signed [67:0] view_coord(int col, logic [31:0] cx,
                                                      logic [31:0] cy, logic [31:0] cz);
        logic signed [67:0] wx, wy, wz, ma, mb, mc, tr, acc;
        wx  = $signed(cx);
        wy  = $signed(cy);
        wz  = $signed(cz);
        ma  = $signed(cull_regs[2*col][31:0]);
        mb  = $signed(cull_regs[2*col][63:32]);
        mc  = $signed(cull_regs[2*col+1][31:0]);
        tr  = $signed(cull_regs[2*col+1][63:32]);
        acc = ((wx * ma + wy * mb + wz * mc) >>> 16) + tr;
        if (acc > 68'sh0_7FFF_FFFF)
            acc = 68'sh0_7FFF_FFFF;
        else if (acc < -68'sh0_8000_0000)
            acc = -68'sh0_8000_0000;
        return acc;
    endfunction

    // plane distance (Q.30) beyond radius (Q16.16), exact
    function automatic logic outside_plane(logic signed [67:0] a, logic signed [67:0] na,
                                           logic signed [67:0] b, logic signed [67:0] nb,
                                           logic signed [67:0] r);
        return (a * na + b * nb) > (r <<< 14);
    endfunction

    function automatic cull_t cull_sphere(logic [31:0] cx, logic [31:0] cy,
                                          logic [31:0] cz, logic [30:0] rad);
        logic signed [67:0] x, y, z, r, near_d, far_d, snx, snz, vny, vnz;
        cull_t c;
        x      = view_coord(0, cx, cy, cz);
        y      = view_coord(1, cx, cy, cz);
        z      = view_coord(2, cx, cy, cz);
        r      = {37'd0, rad};
        near_d = $signed(cull_regs[REG_CLIP][31:0]);
        far_d  = $signed(cull_regs[REG_CLIP][63:32]);
        snx    = $signed(cull_regs[REG_NORMAL][15:0]);
        snz    = $signed(cull_regs[REG_NORMAL][31:16]);
        vny    = $signed(cull_regs[REG_NORMAL][47:32]);
        vnz    = $signed(cull_regs[REG_NORMAL][63:48]);
        if (z + r < near_d)                          c.reason = CULL_NEAR;
        else if (z - r > far_d)                      c.reason = CULL_FAR;
        else if (outside_plane(x, -snx, z, snz, r))  c.reason = CULL_LEFT;
        else if (outside_plane(x, snx, z, snz, r))   c.reason = CULL_RIGHT;
        else if (outside_plane(y, vny, z, vnz, r))   c.reason = CULL_TOP;
        else if (outside_plane(y, -vny, z, vnz, r))  c.reason = CULL_BOTTOM;
        else                                         c.reason = CULL_NONE;
        c.visible = (c.reason == CULL_NONE);
        return c;
    endfunction

    // ---------------------------------------------------------------
    // Monitor: take the typed answer or predict on each accepted request, check each result
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        answer_t a;
        cull_t   want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("sphere_frustum_cull_top regression: fail");
            $finish;
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            a = answer_q.pop_front();
            if (a.typed)
                pending_culls.push_back(a.res);
            else
                pending_culls.push_back(cull_sphere(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                                    s_axis_tdata[95:64],
                                                    s_axis_tdata[126:96]));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_culls.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
            end else begin
                want = pending_culls.pop_front();
                if (m_axis_tdata[0] !== want.visible) begin
                    n_errors++;
                    $display("%0t: visible exp %b got %b", $time, want.visible,
                             m_axis_tdata[0]);
                end
                if (m_axis_tdata[3:1] !== want.reason) begin
                    n_errors++;
                    $display("%0t: cull_reason exp %0d got %0d", $time, want.reason,
                             m_axis_tdata[3:1]);
                end
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= dst_idle);

    task automatic write_reg(t_reg_idx idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        cull_regs[idx] = val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // sender parks until every result is back, plus pipeline slack
    task automatic drain();
        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_culls.size() != 0 || answer_q.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic send_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               logic [30:0] rad, logic typed, cull_t res);
        answer_t a;
        if ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        a.typed = typed;
        a.res   = res;
        answer_q.push_back(a);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, rad, cz, cy, cx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // identity view, near 1.0, far 100.0, 45 degree side planes
    task automatic load_identity();
        write_reg(REG_X_LO,   64'h0000_0000_0001_0000);
        write_reg(REG_X_HI,   64'h0);
        write_reg(REG_Y_LO,   64'h0001_0000_0000_0000);
        write_reg(REG_Y_HI,   64'h0);
        write_reg(REG_Z_LO,   64'h0);
        write_reg(REG_Z_HI,   64'h0000_0000_0001_0000);
        write_reg(REG_CLIP,   64'h0064_0000_0001_0000);
        write_reg(REG_NORMAL, 64'hD2BF_2D41_D2BF_2D41);
    endtask

    function automatic logic [31:0] rand_q(int span);
        return 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    // plausible camera: entries within +-2.0, translation within +-64.0
    task automatic load_random_camera();
        write_reg(REG_X_LO,   {rand_q(32'h2_0000), rand_q(32'h2_0000)});
        write_reg(REG_X_HI,   {rand_q(32'h40_0000), rand_q(32'h2_0000)});
        write_reg(REG_Y_LO,   {rand_q(32'h2_0000), rand_q(32'h2_0000)});
        write_reg(REG_Y_HI,   {rand_q(32'h40_0000), rand_q(32'h2_0000)});
        write_reg(REG_Z_LO,   {rand_q(32'h2_0000), rand_q(32'h2_0000)});
        write_reg(REG_Z_HI,   {rand_q(32'h40_0000), rand_q(32'h2_0000)});
        write_reg(REG_CLIP,   {32'($urandom_range(32'hC8_0000, 32'h10_0000)),
                               32'($urandom_range(32'h5_0000))});
        write_reg(REG_NORMAL, {16'(-$urandom_range(16'h3F00, 16'h0800)),
                               16'($urandom_range(16'h3F00, 16'h0800)),
                               16'(-$urandom_range(16'h3F00, 16'h0800)),
                               16'($urandom_range(16'h3F00, 16'h0800))});
    endtask

    task automatic load_raw(logic [63:0] fill, logic rnd);
        for (int k = 0; k < REG_COUNT; k++)
            write_reg(t_reg_idx'(k), rnd ? {$urandom, $urandom} : fill);
    endtask

    task automatic random_spheres(int count);
        logic [31:0] cx, cy, cz;
        logic [30:0] rad;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(7) == 0) begin
                cx  = $urandom;
                cy  = $urandom;
                cz  = $urandom;
                rad = 31'($urandom);
            end else begin
                cx  = rand_q(32'h80_0000);
                cy  = rand_q(32'h80_0000);
                cz  = rand_q(32'hC0_0000);
                rad = 31'($urandom_range(32'h10_0000));
            end
            send_sphere(cx, cy, cz, rad, 1'b0, '0);
        end
    endtask

    initial begin
        cull_t vis;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_X_LO;
        i_cfg_data    = '0;
        n_errors      = 0;
        cycles        = 0;
        src_idle      = 21;
        dst_idle      = 62;
        for (int k = 0; k < REG_COUNT; k++)
            cull_regs[k] = '0;

        vis.visible = 1'b1;
        vis.reason  = CULL_NONE;
        // all-zero registers: every sphere visible, extremes included
        dir_rows[0]  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1, vis};
        dir_rows[1]  = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0, 1, vis};
        dir_rows[2]  = '{32'h0, 32'h0, 32'h0, 31'h0, 1, vis};
        dir_rows[3]  = '{32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000, 31'h7FFF_FFFF, 1, vis};
        dir_rows[4]  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 31'h1, 1, vis};
        dir_rows[5]  = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 31'h2AAA_AAAA, 1, vis};
        // identity camera: each plane, edge cases for near, far and the right plane
        dir_rows[6]  = '{32'h0, 32'h0, 32'h000A_0000, 31'h1_0000, 0, vis};   // inside
        dir_rows[7]  = '{32'h0, 32'h0, 32'h0000_8000, 31'h0, 0, vis};        // near
        dir_rows[8]  = '{32'h0, 32'h0, 32'h0000_8000, 31'h8000, 0, vis};     // touches near
        dir_rows[9]  = '{32'h0, 32'h0, 32'h00C8_0000, 31'h1_0000, 0, vis};   // far
        dir_rows[10] = '{32'h0, 32'h0, 32'h0065_0000, 31'h1_0000, 0, vis};   // touches far
        dir_rows[11] = '{32'hFFCE_0000, 32'h0, 32'h000A_0000, 31'h1_0000, 0, vis}; // left
        dir_rows[12] = '{32'h0032_0000, 32'h0, 32'h000A_0000, 31'h1_0000, 0, vis}; // right
        dir_rows[13] = '{32'h0, 32'h0032_0000, 32'h000A_0000, 31'h1_0000, 0, vis}; // top
        dir_rows[14] = '{32'h0, 32'hFFCE_0000, 32'h000A_0000, 31'h1_0000, 0, vis}; // bottom
        dir_rows[15] = '{32'h000A_0000, 32'h0, 32'h000A_0000, 31'h0, 0, vis}; // on right plane
        dir_rows[16] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, vis};
        dir_rows[17] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0, 0, vis};
        dir_rows[18] = '{32'h0, 32'h8000_0000, 32'h0032_0000, 31'h7FFF_FFFF, 0, vis};
        dir_rows[19] = '{32'h7FFF_FFFF, 32'h0, 32'h0032_0000, 31'h0, 0, vis};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int k = 0; k < DIR_ROWS; k++) begin
            if (k == ZERO_ROWS) begin
                drain();
                load_identity();
            end
            send_sphere(dir_rows[k].cx, dir_rows[k].cy, dir_rows[k].cz, dir_rows[k].rad,
                        dir_rows[k].typed, dir_rows[k].res);
        end

        // random traffic; camera changes only with the pipe empty
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: load_random_camera();
                1: load_raw(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
                2: load_random_camera();
                3: load_raw('0, 1'b1);
                4: load_identity();
                default: load_random_camera();
            endcase
            if (ph == 2) begin
                src_idle = 62;
                dst_idle = 21;
            end else if (ph == 4) begin
                src_idle = 0;
                dst_idle = 0;
            end
            random_spheres(100);
        end

        drain();
        if (n_errors == 0)
            $display("sphere_frustum_cull_top regression: pass");
        else
            $display("sphere_frustum_cull_top regression: fail");
        $finish;
    end

endmodule
